@@ src/edd_pkg.sv @@
`default_nettype none

package edd_pkg;

  localparam int ERR_W = 10;
  localparam int SUM_W = 12;
  localparam int PIX_W = 8;

  localparam logic signed [SUM_W-1:0] SHARE_RIGHT = 12'sd7;
  localparam logic signed [SUM_W-1:0] SHARE_DOWN_LEFT = 12'sd3;
  localparam logic signed [SUM_W-1:0] SHARE_DOWN = 12'sd5;
  localparam int SHARE_SHIFT = 4;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic signed [SUM_W-1:0] ERR_MIN = -12'sd512;
  localparam logic signed [SUM_W-1:0] ERR_MAX = 12'sd511;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_THRESHOLD    = 2'd2
  } edd_reg_t;

  typedef struct packed {
    logic [7:0] line_width;
    logic [6:0] frame_height;
    logic [7:0] threshold;
  } edd_cfg_t;

  typedef struct packed {
    logic mono_bit;
    logic end_of_line;
    logic end_of_frame;
  } edd_result_t;

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [SUM_W-1:0] v);
    logic signed [ERR_W-1:0] r;
    if (v < ERR_MIN) begin
      r = ERR_MIN[ERR_W-1:0];
    end else if (v > ERR_MAX) begin
      r = ERR_MAX[ERR_W-1:0];
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] err_ext(input logic signed [ERR_W-1:0] v);
    return $signed({{(SUM_W-ERR_W){v[ERR_W-1]}}, v});
  endfunction

endpackage

`default_nettype wire

@@ src/edd_line_store.sv @@
`default_nettype none

module edd_line_store #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [AW-1:0]                rd_addr,
  output logic signed [edd_pkg::ERR_W-1:0]  rd_data,
  input  wire logic                         wr_en,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic signed [edd_pkg::ERR_W-1:0] wr_data,
  output logic                              busy
);
  import edd_pkg::*;

  logic [ERR_W-1:0] mem [DEPTH];
  logic [ERR_W-1:0] ram_q_r;
  logic [ERR_W-1:0] fwd_data_r;
  logic             fwd_r;
  logic             clr_busy_r, clr_busy_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic             we;
  logic [AW-1:0]    wa;
  logic [ERR_W-1:0] wd;

  // clearing sweep takes the write port after reset
  always_comb begin
    if (clr_busy_r) begin
      we = 1'b1;
      wa = clr_addr_r;
      wd = '0;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
    clr_addr_nxt = clr_addr_r + AW'(1);
    clr_busy_nxt = clr_busy_r && (clr_addr_r != AW'(DEPTH - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    ram_q_r    <= mem[rd_addr];
    fwd_r      <= we && (wa == rd_addr);
    fwd_data_r <= wd;
  end

  // write-first on a same-address collision
  assign rd_data = $signed(fwd_r ? fwd_data_r : ram_q_r);
  assign busy    = clr_busy_r;

endmodule

`default_nettype wire

@@ src/edd_core.sv @@
`default_nettype none

module edd_core #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire edd_pkg::edd_cfg_t                cfg,
  input  wire logic                             accept,
  input  wire logic [edd_pkg::PIX_W-1:0]        gray_pixel,
  output edd_pkg::edd_result_t                  result,
  output logic [CW-1:0]                         rd_addr,
  input  wire logic signed [edd_pkg::ERR_W-1:0] rd_data,
  output logic                                  wr_en,
  output logic [CW-1:0]                         wr_addr,
  output logic signed [edd_pkg::ERR_W-1:0]      wr_data
);
  import edd_pkg::*;

  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CMPW  = (CW + 1 > 9) ? CW + 1 : 9;
  localparam int RCMPW = (RW + 1 > 8) ? RW + 1 : 8;

  logic [CW-1:0]           col_r, col_nxt;
  logic [RW-1:0]           row_r, row_nxt;
  logic signed [ERR_W-1:0] right_r, right_nxt;
  logic signed [ERR_W-1:0] diag_r, diag_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  logic [CW-1:0]           pend_addr_r, pend_addr_nxt;
  logic signed [ERR_W-1:0] pend_val_r, pend_val_nxt;

  logic [CMPW-1:0]         w_raw, w_eff;
  logic [RCMPW-1:0]        h_raw, h_eff;
  logic                    eol, last_row, white;
  logic signed [ERR_W-1:0] below;
  logic signed [SUM_W-1:0] sum;
  logic [PIX_W-1:0]        value;
  logic signed [ERR_W-1:0] err;
  logic signed [SUM_W-1:0] err_w, p_right, p_left, p_down;
  logic signed [SUM_W-1:0] s_right, s_left, s_down, s_diag;

  always_comb begin
    w_raw = CMPW'(cfg.line_width);
    if (w_raw == '0) begin
      w_eff = CMPW'(1);
    end else if (w_raw > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_raw = RCMPW'(cfg.frame_height);
    if (h_raw == '0) begin
      h_eff = RCMPW'(1);
    end else if (h_raw > RCMPW'(MAX_HEIGHT)) begin
      h_eff = RCMPW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
    eol      = (CMPW'(col_r) + CMPW'(1)) >= w_eff;
    last_row = (RCMPW'(row_r) + RCMPW'(1)) >= h_eff;

    // newest value of the entry may still sit in the pending slot
    below = (pend_valid_r && (pend_addr_r == col_r)) ? pend_val_r : rd_data;

    sum = $signed({{(SUM_W-PIX_W){1'b0}}, gray_pixel}) + err_ext(right_r) + err_ext(below);
    if (sum < 0) begin
      value = '0;
    end else if (sum > $signed({{(SUM_W-PIX_W){1'b0}}, PIX_MAX})) begin
      value = PIX_MAX;
    end else begin
      value = sum[PIX_W-1:0];
    end
    white = value >= cfg.threshold;
    err   = white ? $signed({2'b00, value}) - $signed({2'b00, PIX_MAX})
                  : $signed({2'b00, value});

    err_w   = err_ext(err);
    p_right = err_w * SHARE_RIGHT;
    p_left  = err_w * SHARE_DOWN_LEFT;
    p_down  = err_w * SHARE_DOWN;
    s_right = p_right >>> SHARE_SHIFT;
    s_left  = err_ext(pend_val_r) + (p_left >>> SHARE_SHIFT);
    s_down  = err_ext(diag_r) + (p_down >>> SHARE_SHIFT);
    s_diag  = err_w >>> SHARE_SHIFT;

    result.mono_bit     = white;
    result.end_of_line  = eol;
    result.end_of_frame = eol && last_row;

    col_nxt        = col_r;
    row_nxt        = row_r;
    right_nxt      = right_r;
    diag_nxt       = diag_r;
    pend_valid_nxt = pend_valid_r;
    pend_addr_nxt  = pend_addr_r;
    pend_val_nxt   = pend_val_r;
    if (accept) begin
      col_nxt        = eol ? '0 : col_r + CW'(1);
      row_nxt        = eol ? (last_row ? '0 : row_r + RW'(1)) : row_r;
      right_nxt      = eol ? '0 : sat_err(s_right);
      diag_nxt       = (eol || last_row) ? '0 : sat_err(s_diag);
      pend_valid_nxt = 1'b1;
      pend_addr_nxt  = col_r;
      pend_val_nxt   = last_row ? '0 : sat_err(s_down);
    end

    // pending entry retires to the store, taking its down-left share first
    wr_en   = accept && pend_valid_r;
    wr_addr = pend_addr_r;
    wr_data = ((col_r != '0) && !last_row) ? sat_err(s_left) : pend_val_r;
    rd_addr = col_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      right_r      <= '0;
      diag_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      right_r      <= right_nxt;
      diag_r       <= diag_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    pend_val_r  <= pend_val_nxt;
  end

endmodule

`default_nettype wire

@@ src/error_diffusion_dither_1bit.sv @@
// Floyd-Steinberg dither of 8-bit gray pixels in raster order to one mono bit per pixel.
// One pixel is taken per clock when the result side keeps up: the error line store is
// read in the cycle before, at the next column, and written once per pixel from a
// one-entry pending slot. After reset the line store is swept to zero, entry by entry,
// and no pixel is taken until the sweep ends; the configuration port is open at all
// times and should be written between frames.
`default_nettype none

module error_diffusion_dither_1bit #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] gray_pixel
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [0] mono_bit, [7:1] zero
  output logic            out_tlast,  // end_of_line
  output logic            out_tuser,  // end_of_frame
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import edd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  edd_cfg_t                cfg_r, cfg_nxt;
  edd_result_t             core_res;
  edd_result_t             out_res_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    accept;
  logic                    store_busy;
  logic [CW-1:0]           rd_addr, wr_addr;
  logic signed [ERR_W-1:0] rd_data, wr_data;
  logic                    wr_en;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (edd_reg_t'(cfg_index))
        REG_LINE_WIDTH:   cfg_nxt.line_width   = cfg_data;
        REG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_data[6:0];
        REG_THRESHOLD:    cfg_nxt.threshold    = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_width   <= 8'd128;
      cfg_r.frame_height <= 7'd64;
      cfg_r.threshold    <= 8'd128;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = !store_busy && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0000000, out_res_r.mono_bit};
  assign out_tlast  = out_res_r.end_of_line;
  assign out_tuser  = out_res_r.end_of_frame;

  edd_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (accept),
    .gray_pixel (in_tdata),
    .result     (core_res),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  edd_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .busy    (store_busy)
  );

endmodule

`default_nettype wire
